[src/stereo_ping_pong_delay_assert.svh]
// assertion macros for the stereo ping-pong delay checker
`ifndef STEREO_PING_PONG_DELAY_ASSERT_SVH
`define STEREO_PING_PONG_DELAY_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SPPD_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPPD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[src/sppd_pkg.sv]
// shared types and constants of the stereo ping-pong delay
`timescale 1ns / 1ps
package sppd_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int LINE_DEPTH_DEF = 65536;

	localparam int AMP_W     = 16;
	localparam int FBG_W     = 16;
	localparam int DLY_W     = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// delays are Q.8
	localparam int FRAC_BITS = 8;
	localparam int FRAC_ONE  = 1 << FRAC_BITS;
	localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);

	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(4096);
	localparam logic [FBG_W-1:0] FBG_RESET = '0;
	localparam logic [DLY_W-1:0] DLY_RESET = DLY_W'(FRAC_ONE);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_GAIN,
		REG_FEEDBACK_GAIN,
		REG_FIRST_DELAY,
		REG_SECOND_DELAY
	} sppd_reg_t;

	// controller to datapath commands
	typedef struct packed {
		logic rd_sel;      // 0: nearer tap, 1: farther tap
		logic ld_in;
		logic mul_first;
		logic mul_second;
		logic ld_fb;
		logic commit;
	} sppd_cmd_t;

endpackage

[src/sppd_if.sv]
// valid/ready channels for the mono input word and the stereo output word
`timescale 1ns / 1ps
interface sppd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sppd_pkg::SAMPLE_BITS-1:0] in_sample;
	logic                                  input_live;

	modport source (output valid, output in_sample, output input_live, input ready);
	modport sink (input valid, input in_sample, input input_live, output ready);
endinterface

interface sppd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sppd_pkg::SAMPLE_BITS-1:0] left_sample;
	logic signed [sppd_pkg::SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

[src/sppd_line.sv]
// one delay line: sample memory, two-tap read and linear interpolation
`timescale 1ns / 1ps
module sppd_line #(
	parameter int LINE_DEPTH = sppd_pkg::LINE_DEPTH_DEF,
	localparam int AW = $clog2(LINE_DEPTH),
	localparam int CW = $clog2(LINE_DEPTH + 1)
) (
	input  logic                                   clk,
	input  sppd_pkg::sppd_cmd_t                    cmd,
	input  logic [AW-1:0]                          wr_pos,
	input  logic [CW-1:0]                          fill,
	input  logic [AW-1:0]                          lag,
	input  logic [sppd_pkg::FRAC_BITS-1:0]         frac,
	input  logic signed [sppd_pkg::SAMPLE_BITS-1:0] wr_sample,
	output logic signed [sppd_pkg::SAMPLE_BITS-1:0] rd_sample
);
	localparam int SB   = sppd_pkg::SAMPLE_BITS;
	localparam int FB   = sppd_pkg::FRAC_BITS;
	localparam int PW   = SB + FB + 2;
	localparam int ACCW = SB + FB + 3;

	logic [SB-1:0] mem [LINE_DEPTH];

	logic [AW:0]            diff;
	logic [AW-1:0]          tap0, tap1, rd_addr;
	logic [SB-1:0]          rdata_q;
	logic                   rvalid_q;
	logic signed [SB-1:0]   tap_s;
	logic [FB:0]            w_near, w_far;
	logic signed [PW-1:0]   near_prod, far_prod, prod_q;
	logic signed [ACCW-1:0] acc;
	logic signed [SB-1:0]   res_q;

	// read index wraps modulo the line depth
	always_comb begin
		diff    = {1'b0, wr_pos} - {1'b0, lag};
		tap0    = diff[AW] ? AW'(diff + (AW+1)'(LINE_DEPTH)) : diff[AW-1:0];
		tap1    = (tap0 == '0) ? AW'(LINE_DEPTH - 1) : tap0 - 1'b1;
		rd_addr = cmd.rd_sel ? tap1 : tap0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			mem[wr_pos] <= wr_sample;
		end
		rdata_q  <= mem[rd_addr];
		// slots not yet written since reset read as silence
		rvalid_q <= (CW'(rd_addr) < fill);
	end

	always_comb begin
		tap_s     = rvalid_q ? $signed(rdata_q) : '0;
		w_near    = (FB+1)'(sppd_pkg::FRAC_ONE) - {1'b0, frac};
		w_far     = {1'b0, frac};
		near_prod = tap_s * $signed({1'b0, w_near});
		far_prod  = tap_s * $signed({1'b0, w_far});
		acc       = ACCW'(prod_q) + ACCW'(far_prod) + ACCW'(sppd_pkg::FRAC_HALF);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_first) begin
			prod_q <= near_prod;
		end
		if (cmd.mul_second) begin
			res_q <= SB'(acc >>> FB);
		end
	end

	assign rd_sample = res_q;

endmodule

[src/sppd_dp.sv]
// datapath: configuration, gain and feedback arithmetic, write position, both lines
`timescale 1ns / 1ps
module sppd_dp #(
	parameter int LINE_DEPTH = sppd_pkg::LINE_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sppd_pkg::sppd_cmd_t                     cmd,
	input  logic signed [sppd_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                                    input_live,
	input  logic                                    wr_en,
	input  logic [sppd_pkg::CFG_IDX_W-1:0]          wr_index,
	input  logic [sppd_pkg::CFG_W-1:0]              wr_data,
	output logic signed [sppd_pkg::SAMPLE_BITS-1:0] left_sample,
	output logic signed [sppd_pkg::SAMPLE_BITS-1:0] right_sample
);
	localparam int SB    = sppd_pkg::SAMPLE_BITS;
	localparam int FB    = sppd_pkg::FRAC_BITS;
	localparam int AW    = $clog2(LINE_DEPTH);
	localparam int CW    = $clog2(LINE_DEPTH + 1);
	localparam int AMP_W = sppd_pkg::AMP_W;
	localparam int FBG_W = sppd_pkg::FBG_W;
	localparam int AMP_FRAC = 12;
	localparam int FBG_FRAC = 15;
	localparam int MW    = SB + AMP_W + 1;
	localparam int SCW   = SB + 5;
	localparam int FBW   = SB + 2;
	localparam int MIXW  = SB + 6;
	localparam int unsigned DELAY_TOP = (LINE_DEPTH - 1) * sppd_pkg::FRAC_ONE;

	function automatic logic [AW+FB-1:0] clamp_delay(input logic [sppd_pkg::DLY_W-1:0] d);
		logic [31:0]      dx;
		logic [AW+FB-1:0] r;
		dx = 32'(d);
		if (dx < 32'(sppd_pkg::FRAC_ONE)) begin
			r = {AW'(1), FB'(0)};
		end else if (dx > DELAY_TOP) begin
			r = {AW'(LINE_DEPTH - 1), FB'(0)};
		end else begin
			r = (AW+FB)'(dx);
		end
		return r;
	endfunction

	logic [AMP_W-1:0] amp_q;
	logic [FBG_W-1:0] fbg_q;
	logic [AW-1:0]    lag1_q, lag2_q;
	logic [FB-1:0]    frac1_q, frac2_q;
	logic [AW-1:0]    wp_q;
	logic [CW-1:0]    fill_q;

	logic signed [SB-1:0]   in_q;
	logic signed [MW-1:0]   amp_prod, fb_prod;
	logic signed [SCW-1:0]  scaled_q;
	logic signed [FBW-1:0]  fb_q;
	logic signed [MIXW-1:0] mix;
	logic signed [SB-1:0]   left, first_rd, second_rd;
	logic signed [SB-1:0]   left_q, right_q;

	// delays are stored already clamped as lag and fraction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q             <= sppd_pkg::AMP_RESET;
			fbg_q             <= sppd_pkg::FBG_RESET;
			{lag1_q, frac1_q} <= clamp_delay(sppd_pkg::DLY_RESET);
			{lag2_q, frac2_q} <= clamp_delay(sppd_pkg::DLY_RESET);
		end else if (wr_en) begin
			unique case (sppd_pkg::sppd_reg_t'(wr_index))
				sppd_pkg::REG_AMP_GAIN:      amp_q <= wr_data[AMP_W-1:0];
				sppd_pkg::REG_FEEDBACK_GAIN: fbg_q <= wr_data[FBG_W-1:0];
				sppd_pkg::REG_FIRST_DELAY: begin
					{lag1_q, frac1_q} <= clamp_delay(wr_data[sppd_pkg::DLY_W-1:0]);
				end
				sppd_pkg::REG_SECOND_DELAY: begin
					{lag2_q, frac2_q} <= clamp_delay(wr_data[sppd_pkg::DLY_W-1:0]);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.commit) begin
			wp_q <= (wp_q == AW'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (fill_q != CW'(LINE_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_comb begin
		amp_prod = in_q * $signed({1'b0, amp_q});
		fb_prod  = second_rd * $signed({1'b0, fbg_q});
		mix      = MIXW'(scaled_q) + MIXW'(fb_q);
		// saturate when the bits above the sample width are not all sign
		if (mix[MIXW-1:SB-1] == '0 || mix[MIXW-1:SB-1] == '1) begin
			left = mix[SB-1:0];
		end else if (mix[MIXW-1]) begin
			left = {1'b1, {(SB-1){1'b0}}};
		end else begin
			left = {1'b0, {(SB-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			in_q <= input_live ? in_sample : '0;
		end
		if (cmd.mul_first) begin
			scaled_q <= SCW'((amp_prod + MW'(1 << (AMP_FRAC - 1))) >>> AMP_FRAC);
		end
		if (cmd.ld_fb) begin
			fb_q <= FBW'((fb_prod + MW'(1 << (FBG_FRAC - 1))) >>> FBG_FRAC);
		end
		if (cmd.commit) begin
			left_q  <= left;
			right_q <= first_rd;
		end
	end

	sppd_line #(.LINE_DEPTH(LINE_DEPTH)) u_first (
		.clk       (clk),
		.cmd       (cmd),
		.wr_pos    (wp_q),
		.fill      (fill_q),
		.lag       (lag1_q),
		.frac      (frac1_q),
		.wr_sample (left),
		.rd_sample (first_rd)
	);

	// interpolated read of in-range samples needs no saturation
	sppd_line #(.LINE_DEPTH(LINE_DEPTH)) u_second (
		.clk       (clk),
		.cmd       (cmd),
		.wr_pos    (wp_q),
		.fill      (fill_q),
		.lag       (lag2_q),
		.frac      (frac2_q),
		.wr_sample (first_rd),
		.rd_sample (second_rd)
	);

	assign left_sample  = left_q;
	assign right_sample = right_q;

endmodule

[src/sppd_ctrl.sv]
// controller: sequences the reads, multiplies and the commit of one word
`timescale 1ns / 1ps
module sppd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output sppd_pkg::sppd_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ_FAR,
		S_INTERP,
		S_FEEDBACK,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.ld_in  = in_valid;
			end
			S_READ_FAR: begin
				cmd.rd_sel    = 1'b1;
				cmd.mul_first = 1'b1;
			end
			S_INTERP:   cmd.mul_second = 1'b1;
			S_FEEDBACK: cmd.ld_fb      = 1'b1;
			S_COMMIT:   cmd.commit     = out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE:     if (in_valid) state_q <= S_READ_FAR;
				S_READ_FAR: state_q <= S_INTERP;
				S_INTERP:   state_q <= S_FEEDBACK;
				S_FEEDBACK: state_q <= S_COMMIT;
				S_COMMIT:   if (out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/stereo_ping_pong_delay.sv]
// top level of the stereo ping-pong delay
// Each mono input word yields one stereo output word. For an accepted word
// the nearer tap of both lines is read at acceptance, the farther tap in the
// next cycle through the single read port of each line memory, then come
// interpolation, the feedback multiply and the commit that writes both lines
// and loads the output register. A new word is taken only once the block is
// back in idle after that commit; a result waiting in the output register
// does not stop the next word from being accepted, only its commit. Line
// contents after reset read as zero through a fill count, so no clearing
// pass is needed. The user must write registers only while no word is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
module stereo_ping_pong_delay #(
	parameter int LINE_DEPTH = sppd_pkg::LINE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sppd_in_if.sink                        sample_ch,
	sppd_out_if.source                     stereo_ch,
	input  logic                           wr_en,
	input  logic [sppd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [sppd_pkg::CFG_W-1:0]     wr_data
);
	sppd_pkg::sppd_cmd_t cmd;

	sppd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.out_valid (stereo_ch.valid),
		.out_ready (stereo_ch.ready),
		.cmd       (cmd)
	);

	sppd_dp #(.LINE_DEPTH(LINE_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_sample    (sample_ch.in_sample),
		.input_live   (sample_ch.input_live),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.left_sample  (stereo_ch.left_sample),
		.right_sample (stereo_ch.right_sample)
	);

endmodule

[src/sppd_checker.sv]
// port-level checker for the stereo ping-pong delay and its bind
`timescale 1ns / 1ps
`include "stereo_ping_pong_delay_assert.svh"
module sppd_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [sppd_pkg::SAMPLE_BITS-1:0] left_sample,
	input logic signed [sppd_pkg::SAMPLE_BITS-1:0] right_sample
);
	logic       in_acc, out_acc;
	logic [1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`SPPD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "output word dropped while stalled")
	`SPPD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(left_sample) && $stable(right_sample), "output word changed while stalled")
	`SPPD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_acc, !in_ready, "second word taken while one is in work")
	`SPPD_ASSERT_SAME(a_no_invented, clk, arst_n, out_valid, pending_q != 2'd0, "output word without an accepted input word")

endmodule

bind stereo_ping_pong_delay sppd_checker u_sppd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample_ch.valid),
	.in_ready     (sample_ch.ready),
	.out_valid    (stereo_ch.valid),
	.out_ready    (stereo_ch.ready),
	.left_sample  (stereo_ch.left_sample),
	.right_sample (stereo_ch.right_sample)
);
